// ----- hw/rtl/lcg48_pkg.sv -----
// Shared types and constants for the 48-bit LCG random generator.
package lcg48_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned REG_W    = 48;
  localparam int unsigned BOUND_W  = 32;
  localparam int unsigned REDRAW_W = 7;
  localparam logic [REDRAW_W-1:0] MAX_REDRAWS = 7'd64;

  localparam logic [REG_W-1:0] RESET_MULT = 48'd25214903917;
  localparam logic [REG_W-1:0] RESET_ADD  = 48'd11;

  typedef enum logic [KIND_W-1:0] {
    KIND_BITS   = 3'd0,
    KIND_BOUND  = 3'd1,
    KIND_LONG   = 3'd2,
    KIND_BOOL   = 3'd3,
    KIND_FLOAT  = 3'd4,
    KIND_DOUBLE = 3'd5,
    KIND_RESEED = 3'd6,
    KIND_BAD    = 3'd7
  } kind_e;

  typedef enum logic {
    REG_MULT = 1'b0,
    REG_ADD  = 1'b1
  } reg_idx_e;

  // Request to the shared multiply unit and its completion.
  typedef struct packed {
    logic start;
  } mul_req_t;

  typedef struct packed {
    logic done;
  } mul_rsp_t;

  // Request to the shared divider unit and its completion.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

// ----- hw/rtl/lcg48_mul.sv -----
// Shift-add multiplier that computes (a * b + c) mod 2^W, one bit of b per cycle.
module lcg48_mul #(
  parameter int unsigned W = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcg48_pkg::mul_req_t   req_i,
  input  logic [W-1:0]          a_i,
  input  logic [W-1:0]          b_i,
  input  logic [W-1:0]          c_i,
  output lcg48_pkg::mul_rsp_t   rsp_o,
  output logic [W-1:0]          prod_o
);
  import lcg48_pkg::*;

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     a_q, a_d;
  logic [W-1:0]     b_q, b_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = c_i;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = CNT_W'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = {a_q[W-2:0], 1'b0};
      b_d   = {1'b0, b_q[W-1:1]};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1) || b_q[W-1:1] == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

// ----- hw/rtl/lcg48_div.sv -----
// Restoring divider giving the remainder of a 31-bit value by a 32-bit divisor.
module lcg48_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcg48_pkg::div_req_t req_i,
  input  logic [30:0]         num_i,
  input  logic [31:0]         den_i,
  output lcg48_pkg::div_rsp_t rsp_o,
  output logic [31:0]         rem_o
);
  import lcg48_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [30:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[30]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      cnt_d  = 5'd30;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
      end else begin
        rem_d = {rem_q[30:0], num_q[30]};
      end
      num_d = {num_q[29:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

// ----- hw/rtl/lcg48_random_generator.sv -----
// Top level of the 48-bit LCG random generator: sequencer, state and registers.
//
// Usage:
//   A request enters on the input channel (in_valid_i / in_stall_o) with
//   kind_i, bit_count_i, upper_bound_i and seed_in_i. Exactly one result
//   leaves on the output channel (out_valid_o / out_stall_i) as value_o and
//   error_o. The input stalls from acceptance until the result is taken.
//   Every draw runs the shift-add multiplier, then adds the addend and
//   extracts bits. A raw, boolean or float request takes one draw, long
//   and double two draws. A bounded int that is not a power of two also
//   runs the serial divider per candidate, with up to 64 redraws. Reseed
//   and illegal requests go straight from idle to the result state.
//   Configuration writes (cfg_valid_i / cfg_ready_o, index 0 multiplier,
//   index 1 addend) are taken at any time and do not touch the state.
//   After reset the multiplier and addend hold their defaults and the state
//   holds the default multiplier. A stalled result holds on the outputs.
module lcg48_random_generator #(
  parameter int unsigned STATE_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [5:0]  bit_count_i,
  input  logic signed [31:0] upper_bound_i,
  input  logic signed [63:0] seed_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [63:0] value_o,
  output logic        error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import lcg48_pkg::*;

  localparam int unsigned SB = STATE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAW,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e            st_q;
  logic [REG_W-1:0]  mult_q, add_q;
  logic [SB-1:0]     lcg_q;
  kind_e             kind_q;
  logic [5:0]        bits_q;
  logic [BOUND_W-1:0] bnd_q;
  logic              second_q;
  logic [31:0]       first_q;
  logic [30:0]       u_q;
  logic [REDRAW_W-1:0] tries_q;
  logic [63:0]       value_q;
  logic              err_q;
  logic              div_go_q;

  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [SB-1:0]     prod;
  logic [31:0]       rem;
  logic [SB-1:0]     next_state;
  logic [SB-1:0]     mul_a;
  logic [5:0]        draw_bits;
  logic [31:0]       drawn;
  logic [SB-1:0]     mult_ext, add_ext;
  logic              bnd_pow2;
  logic [31:0]       rej_chk;
  logic [62:0]       pow_prod;

  assign mult_ext = SB'(mult_q);
  assign add_ext  = SB'(add_q);

  // A second draw starts while the new state is still being formed.
  assign mul_a = (st_q == ST_DRAW) ? next_state : lcg_q;

  lcg48_mul #(.W(SB)) u_mul (
    .clk_i, .rst_ni,
    .req_i(mul_req), .a_i(mul_a), .b_i(mult_ext), .c_i('0),
    .rsp_o(mul_rsp), .prod_o(prod)
  );

  lcg48_div u_div (
    .clk_i, .rst_ni,
    .req_i(div_req), .num_i(u_q), .den_i(bnd_q),
    .rsp_o(div_rsp), .rem_o(rem)
  );

  assign next_state = prod + add_ext;

  always_comb begin
    case (kind_q)
      KIND_BITS:   draw_bits = bits_q;
      KIND_BOUND:  draw_bits = 6'd31;
      KIND_LONG:   draw_bits = 6'd32;
      KIND_BOOL:   draw_bits = 6'd1;
      KIND_FLOAT:  draw_bits = 6'd24;
      KIND_DOUBLE: draw_bits = second_q ? 6'd27 : 6'd26;
      default:     draw_bits = 6'd0;
    endcase
  end

  // Top draw_bits bits of the new state, right aligned.
  always_comb begin
    logic [SB+31:0] wide;
    wide  = {next_state, 32'd0} >> (32 + SB - int'(draw_bits));
    drawn = (draw_bits == 6'd0) ? 32'd0 : wide[31:0];
  end

  assign bnd_pow2 = (bnd_q & (bnd_q - 32'd1)) == '0;
  assign rej_chk  = {1'b0, u_q} - rem + (bnd_q - 32'd1);
  assign pow_prod = 63'(bnd_q) * 63'(drawn[30:0]);

  assign in_stall_o  = (st_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (st_q == ST_OUT);
  assign value_o     = value_q;
  assign error_o     = err_q;

  always_comb begin
    mul_req.start = 1'b0;
    if (st_q == ST_IDLE && in_valid_i) begin
      mul_req.start = kind_e'(kind_i) != KIND_RESEED && kind_e'(kind_i) != KIND_BAD;
    end
    if (st_q == ST_DRAW) begin
      // Launch the next draw when more bits are needed.
      if ((kind_q == KIND_LONG || kind_q == KIND_DOUBLE) && !second_q) begin
        mul_req.start = 1'b1;
      end
    end
    if (st_q == ST_DIV && div_rsp.done && rej_chk[31] && tries_q < MAX_REDRAWS) begin
      mul_req.start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      mult_q   <= RESET_MULT;
      add_q    <= RESET_ADD;
      lcg_q    <= SB'(RESET_MULT);
      second_q <= 1'b0;
      tries_q  <= '0;
      kind_q   <= KIND_BITS;
      bits_q   <= '0;
      bnd_q    <= '0;
      first_q  <= '0;
      u_q      <= '0;
      value_q  <= '0;
      err_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_MULT: mult_q <= cfg_data_i;
          REG_ADD:  add_q  <= cfg_data_i;
          default:  ;
        endcase
      end
      case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            kind_q   <= kind_e'(kind_i);
            bits_q   <= bit_count_i;
            bnd_q    <= upper_bound_i;
            second_q <= 1'b0;
            tries_q  <= '0;
            value_q  <= '0;
            err_q    <= 1'b0;
            st_q     <= ST_MUL;
            case (kind_e'(kind_i))
              KIND_BITS: begin
                if (bit_count_i > 6'd32) begin
                  err_q <= 1'b1;
                  st_q  <= ST_OUT;
                end
              end
              KIND_BOUND: begin
                if (upper_bound_i <= 0) begin
                  err_q <= 1'b1;
                  st_q  <= ST_OUT;
                end
              end
              KIND_RESEED: begin
                lcg_q <= SB'(seed_in_i ^ 64'(mult_q));
                st_q  <= ST_OUT;
              end
              KIND_BAD: begin
                err_q <= 1'b1;
                st_q  <= ST_OUT;
              end
              default: ;
            endcase
            // An illegal request may still start the multiplier; drop its result.
          end
        end
        ST_MUL: begin
          if (mul_rsp.done) begin
            st_q <= ST_DRAW;
          end
        end
        ST_DRAW: begin
          lcg_q <= next_state;
          case (kind_q)
            KIND_BITS: begin
              value_q <= {{32{drawn[31]}}, drawn};
              st_q    <= ST_OUT;
            end
            KIND_BOUND: begin
              u_q <= drawn[30:0];
              if (tries_q == '0 && bnd_pow2) begin
                value_q <= 64'(pow_prod[62:31]);
                st_q    <= ST_OUT;
              end else begin
                st_q <= ST_DIV;
              end
            end
            KIND_LONG: begin
              if (!second_q) begin
                first_q  <= drawn;
                second_q <= 1'b1;
                st_q     <= ST_MUL;
              end else begin
                value_q <= {first_q, 32'd0} + {{32{drawn[31]}}, drawn};
                st_q    <= ST_OUT;
              end
            end
            KIND_DOUBLE: begin
              if (!second_q) begin
                first_q  <= drawn;
                second_q <= 1'b1;
                st_q     <= ST_MUL;
              end else begin
                value_q <= {first_q[25:0], 27'd0} + 64'(drawn[26:0]);
                st_q    <= ST_OUT;
              end
            end
            default: begin
              value_q <= 64'(drawn);
              st_q    <= ST_OUT;
            end
          endcase
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            value_q <= 64'(rem);
            if (rej_chk[31] && tries_q < MAX_REDRAWS) begin
              tries_q <= tries_q + REDRAW_W'(1);
              st_q    <= ST_MUL;
            end else begin
              st_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Divider start: registered from the ST_DRAW decision, so it is high as ST_DIV is entered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_go_q <= 1'b0;
    end else begin
      div_go_q <= (st_q == ST_DRAW) && (kind_q == KIND_BOUND)
                  && !(tries_q == '0 && bnd_pow2);
    end
  end

  always_comb begin
    div_req.start = div_go_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> value_o == '0)
    else $error("error result carries a value");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_q == KIND_BOOL |-> value_o[63:1] == '0)
    else $error("boolean out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_q == KIND_BOUND && !error_o |-> value_o < 64'(bnd_q))
    else $error("bounded result out of range");

endmodule
